// ----- rtl/core/lmo_pkg.sv -----
package lmo_pkg;

    // request kinds carried in s_axis_tuser
    localparam logic [1:0] REQ_DECODE = 2'd0;
    localparam logic [1:0] REQ_WR_SEG = 2'd1;
    localparam logic [1:0] REQ_WR_TIM = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // config register indexes
    localparam logic [2:0] CFG_TANG = 3'd0;
    localparam logic [2:0] CFG_VIEW = 3'd1;
    localparam logic [2:0] CFG_SINO = 3'd2;
    localparam logic [2:0] CFG_SEG  = 3'd3;
    localparam logic [2:0] CFG_TOF  = 3'd4;

    // request fields and digits gathered so far
    typedef struct packed {
        logic [1:0]        req;
        logic [6:0]        idx;
        logic signed [7:0] eseg;
        logic [7:0]        easz;
        logic signed [6:0] etim;
        logic [9:0]        tang;
        logic [9:0]        view;
    } item_t;

    // state of the segment walk
    typedef struct packed {
        item_t       it;
        logic [12:0] z;
        logic [29:0] tof;
        logic        found;
        logic [7:0]  seg;
        logic [7:0]  axial;
    } walk_t;

endpackage

// ----- rtl/core/lmo_div.sv -----
module lmo_div #(
    parameter int NW = 30,
    parameter int DW = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [NW-1:0]         in_num,
    input  logic [DW-1:0]         divisor,
    input  lmo_pkg::item_t        in_item,
    output logic                  out_valid,
    output logic [NW-1:0]         out_quot,
    output logic [DW-1:0]         out_rem,
    output lmo_pkg::item_t        out_item
);

    logic           v_reg  [NW];
    logic [NW-1:0]  n_reg  [NW];
    logic [DW-1:0]  r_reg  [NW];
    lmo_pkg::item_t it_reg [NW];

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic           v_prev;
        logic [NW-1:0]  n_prev;
        logic [DW-1:0]  r_prev;
        lmo_pkg::item_t it_prev;
        logic [DW:0]    trial;
        logic           ge;
        logic [DW-1:0]  r_next;
        logic [NW-1:0]  n_next;

        if (k == 0) begin : g_first
            assign v_prev  = in_valid;
            assign n_prev  = in_num;
            assign r_prev  = '0;
            assign it_prev = in_item;
        end else begin : g_rest
            assign v_prev  = v_reg[k-1];
            assign n_prev  = n_reg[k-1];
            assign r_prev  = r_reg[k-1];
            assign it_prev = it_reg[k-1];
        end

        always_comb
        begin
            trial  = {r_prev, n_prev[NW-1]};
            ge     = trial >= {1'b0, divisor};
            r_next = ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
            n_next = {n_prev[NW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k]  <= n_next;
                r_reg[k]  <= r_next;
                it_reg[k] <= it_prev;
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign out_quot  = n_reg[NW-1];
    assign out_rem   = r_reg[NW-1];
    assign out_item  = it_reg[NW-1];

endmodule

// ----- rtl/core/lmo_seg.sv -----
module lmo_seg #(
    parameter int NSEG = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic [7:0]     segment_count,
    input  logic           in_valid,
    input  lmo_pkg::walk_t in_walk,
    output logic           out_valid,
    output lmo_pkg::walk_t out_walk
);

    logic           v_reg [NSEG];
    lmo_pkg::walk_t w_reg [NSEG];

    // one stage per table entry, each entry held beside its stage
    for (genvar i = 0; i < NSEG; i++) begin : g_stage
        logic           v_prev;
        lmo_pkg::walk_t w_prev;
        lmo_pkg::walk_t w_next;
        logic [7:0]     seg_e_reg;
        logic [7:0]     asz_e_reg;
        logic           wr;
        logic           active;

        if (i == 0) begin : g_first
            assign v_prev = in_valid;
            assign w_prev = in_walk;
        end else begin : g_rest
            assign v_prev = v_reg[i-1];
            assign w_prev = w_reg[i-1];
        end

        assign wr = en && v_prev && (w_prev.it.req == lmo_pkg::REQ_WR_SEG)
                    && (9'(i) == {2'b00, w_prev.it.idx});
        assign active = (9'(i) < {1'b0, segment_count}) && !w_prev.found;

        // compare and subtract against this entry
        always_comb
        begin
            w_next = w_prev;
            if (active)
            begin
                if (w_prev.z < {5'b0, asz_e_reg})
                begin
                    w_next.found = 1'b1;
                    w_next.seg   = seg_e_reg;
                    w_next.axial = w_prev.z[7:0];
                end
                else
                    w_next.z = w_prev.z - {5'b0, asz_e_reg};
            end
        end

        always_ff @(posedge clk)
        begin
            if (wr)
            begin
                seg_e_reg <= w_prev.it.eseg;
                asz_e_reg <= w_prev.it.easz;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                w_reg[i] <= w_next;
        end
    end

    assign out_valid = v_reg[NSEG-1];
    assign out_walk  = w_reg[NSEG-1];

endmodule

// ----- rtl/core/lmo_tof.sv -----
module lmo_tof #(
    parameter int NTOF = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [4:0]        tof_bin_count,
    input  logic [9:0]        half_tang,
    input  logic              in_valid,
    input  lmo_pkg::walk_t    in_walk,
    output logic              out_valid,
    output logic signed [7:0] seg_no,
    output logic [7:0]        axial_pos,
    output logic [9:0]        view_no,
    output logic signed [9:0] tangential_pos,
    output logic signed [6:0] timing_pos,
    output logic              decode_error
);

    localparam int TW = (NTOF > 1) ? $clog2(NTOF) : 1;

    logic [6:0]        tim_mem [NTOF];
    logic              in_range;
    logic              wr;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        seg_reg;
    logic [7:0]        axial_reg;
    logic [9:0]        view_reg;
    logic [9:0]        tang_reg;
    logic [6:0]        tim_reg;
    logic              err_reg;

    assign in_range = (in_walk.tof < 30'(NTOF)) && (in_walk.tof < {25'b0, tof_bin_count});
    assign wr = en && in_valid && (in_walk.it.req == lmo_pkg::REQ_WR_TIM)
                && ({1'b0, in_walk.it.idx} < 8'(NTOF));
    assign out_valid_next = in_valid && (in_walk.it.req == lmo_pkg::REQ_DECODE);

    // timing table write
    always_ff @(posedge clk)
    begin
        if (wr)
            tim_mem[in_walk.it.idx[TW-1:0]] <= in_walk.it.etim;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= out_valid_next;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_reg   <= in_walk.found ? in_walk.seg : 8'd0;
            axial_reg <= in_walk.found ? in_walk.axial : 8'd0;
            view_reg  <= in_walk.it.view;
            tang_reg  <= in_walk.it.tang - half_tang;
            tim_reg   <= in_range ? tim_mem[in_walk.tof[TW-1:0]] : 7'd0;
            err_reg   <= !in_walk.found || !in_range;
        end
    end

    assign out_valid      = out_valid_reg;
    assign seg_no         = seg_reg;
    assign axial_pos      = axial_reg;
    assign view_no        = view_reg;
    assign tangential_pos = tang_reg;
    assign timing_pos     = tim_reg;
    assign decode_error   = err_reg;

endmodule

// ----- rtl/core/listmode_offset_to_sinogram_bin_top.sv -----
// throughput: one beat per cycle while no result beat is held; three
// 30-stage restoring dividers (one quotient bit per stage), one walk stage
// per segment table entry and a timing lookup stage, all in step
// a stalled result beat holds the whole pipeline, input included
// reset: rst_n clears valid bits and config registers (all counts to 1);
// table contents stay undefined until written by table-write beats
module listmode_offset_to_sinogram_bin_top #(
    parameter int MAX_SEGMENTS = 128,
    parameter int MAX_TOF_BINS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // event_offset[29:0], table_index[36:30], entry_segment[44:37],
    // entry_axial_size[52:45], entry_timing[59:53], zero fill
    input  logic [63:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // segment number[7:0], axial_pos[15:8], view number[25:16],
    // tangential_pos[35:26], timing_pos[42:36], decode_error[43], zero fill
    output logic [47:0] m_axis_tdata
);

    logic [9:0]  tang_cnt_reg;
    logic [9:0]  view_cnt_reg;
    logic [12:0] sino_cnt_reg;
    logic [7:0]  seg_cnt_reg;
    logic [4:0]  tof_cnt_reg;
    logic [9:0]  tc;
    logic [9:0]  vc;
    logic [12:0] sc;
    logic        en;

    lmo_pkg::item_t it0;
    lmo_pkg::item_t it1;
    lmo_pkg::item_t it1m;
    lmo_pkg::item_t it2;
    lmo_pkg::item_t it2m;
    lmo_pkg::item_t it3;
    logic           v1;
    logic           v2;
    logic           v3;
    logic           v4;
    logic [29:0]    q1;
    logic [29:0]    q2;
    logic [29:0]    q3;
    logic [9:0]     r1;
    logic [9:0]     r2;
    logic [12:0]    r3;
    lmo_pkg::walk_t w0;
    lmo_pkg::walk_t w4;

    logic signed [7:0] seg_no;
    logic [7:0]        axial_pos;
    logic [9:0]        view_no;
    logic signed [9:0] tangential_pos;
    logic signed [6:0] timing_pos;
    logic              decode_error;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tang_cnt_reg <= 10'd1;
            view_cnt_reg <= 10'd1;
            sino_cnt_reg <= 13'd1;
            seg_cnt_reg  <= 8'd1;
            tof_cnt_reg  <= 5'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lmo_pkg::CFG_TANG: tang_cnt_reg <= cfg_data[9:0];
                lmo_pkg::CFG_VIEW: view_cnt_reg <= cfg_data[9:0];
                lmo_pkg::CFG_SINO: sino_cnt_reg <= cfg_data;
                lmo_pkg::CFG_SEG:  seg_cnt_reg  <= cfg_data[7:0];
                lmo_pkg::CFG_TOF:  tof_cnt_reg  <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // zero counts act as one
    assign tc = (tang_cnt_reg == 10'd0) ? 10'd1 : tang_cnt_reg;
    assign vc = (view_cnt_reg == 10'd0) ? 10'd1 : view_cnt_reg;
    assign sc = (sino_cnt_reg == 13'd0) ? 13'd1 : sino_cnt_reg;

    // whole pipeline advances unless the result beat is held
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        it0      = '0;
        it0.req  = s_axis_tuser;
        it0.idx  = s_axis_tdata[36:30];
        it0.eseg = s_axis_tdata[44:37];
        it0.easz = s_axis_tdata[52:45];
        it0.etim = s_axis_tdata[59:53];
    end

    // tangential digit
    lmo_div #(.NW(30), .DW(10)) u_div_tang (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_axis_tvalid), .in_num(s_axis_tdata[29:0]), .divisor(tc),
        .in_item(it0),
        .out_valid(v1), .out_quot(q1), .out_rem(r1), .out_item(it1)
    );

    always_comb
    begin
        it1m      = it1;
        it1m.tang = r1;
    end

    // view digit
    lmo_div #(.NW(30), .DW(10)) u_div_view (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v1), .in_num(q1), .divisor(vc), .in_item(it1m),
        .out_valid(v2), .out_quot(q2), .out_rem(r2), .out_item(it2)
    );

    always_comb
    begin
        it2m      = it2;
        it2m.view = r2;
    end

    // sinogram index and tof bin
    lmo_div #(.NW(30), .DW(13)) u_div_sino (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v2), .in_num(q2), .divisor(sc), .in_item(it2m),
        .out_valid(v3), .out_quot(q3), .out_rem(r3), .out_item(it3)
    );

    always_comb
    begin
        w0       = '0;
        w0.it    = it3;
        w0.z     = r3;
        w0.tof   = q3;
    end

    lmo_seg #(.NSEG(MAX_SEGMENTS)) u_seg (
        .clk(clk), .rst_n(rst_n), .en(en), .segment_count(seg_cnt_reg),
        .in_valid(v3), .in_walk(w0),
        .out_valid(v4), .out_walk(w4)
    );

    lmo_tof #(.NTOF(MAX_TOF_BINS)) u_tof (
        .clk(clk), .rst_n(rst_n), .en(en), .tof_bin_count(tof_cnt_reg),
        .half_tang({1'b0, tc[9:1]}),
        .in_valid(v4), .in_walk(w4),
        .out_valid(m_axis_tvalid),
        .seg_no(seg_no), .axial_pos(axial_pos), .view_no(view_no),
        .tangential_pos(tangential_pos), .timing_pos(timing_pos),
        .decode_error(decode_error)
    );

    assign m_axis_tdata = {4'b0, decode_error, timing_pos, tangential_pos,
                           view_no, axial_pos, seg_no};

    // held result stalls the input side
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while result held");

    // divisors are never zero
    a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
        (tc != 10'd0) && (vc != 10'd0) && (sc != 13'd0))
        else $error("zero divisor");

    // a result beat only leaves after a handshake
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("result beat dropped");

    // a decode with a tof bin out of range reports an error
    a_tof_err: assert property (@(posedge clk) disable iff (!rst_n)
        (en && v4 && (w4.it.req == lmo_pkg::REQ_DECODE)
         && (w4.tof >= {25'b0, tof_cnt_reg})) |=> decode_error)
        else $error("tof range error missed");

endmodule
